// ===== rtl/qcw_pkg.sv =====
// Shared widths, codes and transaction types for the quad centroid unit.
`timescale 1ns / 1ps
package qcw_pkg;

   // Coordinate width used inside the datapath (low bits of each field).
   localparam int COORD_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int SUM_W       = COORD_WIDTH + 2;
   localparam int MUL_W       = SUM_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int CROSS_W     = 2 * DIFF_W + 1;
   localparam int NUM_W       = CROSS_W + SUM_W + 2;
   localparam int AREA_W      = CROSS_W + 2;
   localparam int DEN_W       = AREA_W + 2;
   localparam int DIV_CNT_W   = $clog2(NUM_W);

   localparam logic [2:0] VERTS_HELD = 3'd3;
   localparam logic [2:0] COUNT_MAX  = 3'd7;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] TRI_LAST = 2'd3;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_COUNT = 2'd1,
      ST_AREA  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CRX_LD,
      OP_CRY_LD,
      OP_MUL,
      OP_CR_SET,
      OP_CR_SUB,
      OP_ABS,
      OP_AREA,
      OP_NLO_LD,
      OP_NHI_LD,
      OP_NLO_ACC,
      OP_NHI_ACC,
      OP_ROT,
      OP_DEN,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_DONE,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] centroid_x;
      logic signed [31:0] centroid_y;
      logic signed [31:0] centroid_z;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic       shift_in;
      logic       load_last;
      logic       clear;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
   } dp_status_type;

endpackage

// ===== rtl/qcw_datapath.sv =====
// Datapath: vertex registers, shared multiplier, accumulators, divider, output register.
`timescale 1ns / 1ps
module qcw_datapath
   import qcw_pkg::*;
(
   input  logic          clock,
   input  cmd_type       cmd,
   input  req_type       req_data,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   localparam logic [NUM_W-1:0] LIM_POS = NUM_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'd1 << (COORD_WIDTH - 1));

   logic signed [COORD_WIDTH-1:0] p_ff [4][3];
   logic signed [MUL_W-1:0]       opa_ff, opb_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [CROSS_W-1:0]     cr_ff;
   logic [CROSS_W-1:0]            a2_ff;
   logic [AREA_W-1:0]             area_ff;
   logic [DEN_W-1:0]              den_ff;
   logic signed [NUM_W-1:0]       num_ff [3];
   logic [NUM_W-1:0]              quo_ff;
   logic [DEN_W-1:0]              rem_ff;
   logic                          neg_ff;
   logic signed [OUT_WIDTH-1:0]   res_ff [3];
   rsp_type                       rsp_ff;

   logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
   logic signed [COORD_WIDTH-1:0] ca0, ca1, ca2;
   logic signed [MUL_W-1:0]       axis_sum;
   logic signed [NUM_W-1:0]       num_sel;
   logic [NUM_W-1:0]              num_mag;
   logic [DEN_W:0]                shifted;
   logic                          fits;
   logic                          big;
   logic [COORD_WIDTH-1:0]        res_cw;

   // Take the low coordinate bits of each field
   assign in_x = signed'(req_data.vertex_x[COORD_WIDTH-1:0]);
   assign in_y = signed'(req_data.vertex_y[COORD_WIDTH-1:0]);
   assign in_z = signed'(req_data.vertex_z[COORD_WIDTH-1:0]);

   // Select the axis column of the current triangle
   always_comb begin
      case (cmd.axis)
         AXIS_Y: begin
            ca0 = p_ff[0][1]; ca1 = p_ff[1][1]; ca2 = p_ff[2][1];
            num_sel = num_ff[1];
         end
         AXIS_Z: begin
            ca0 = p_ff[0][2]; ca1 = p_ff[1][2]; ca2 = p_ff[2][2];
            num_sel = num_ff[2];
         end
         default: begin
            ca0 = p_ff[0][0]; ca1 = p_ff[1][0]; ca2 = p_ff[2][0];
            num_sel = num_ff[0];
         end
      endcase
      axis_sum = MUL_W'(ca0) + MUL_W'(ca1) + MUL_W'(ca2);
      num_mag  = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
   end

   // Divider trial and saturation
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      big     = neg_ff ? (quo_ff > LIM_NEG) : (quo_ff > LIM_POS);
      if (neg_ff) begin
         res_cw = big ? LIM_NEG[COORD_WIDTH-1:0] : COORD_WIDTH'(-quo_ff[COORD_WIDTH-1:0]);
      end else begin
         res_cw = big ? LIM_POS[COORD_WIDTH-1:0] : quo_ff[COORD_WIDTH-1:0];
      end
   end

   // Vertex registers: shift in the first three, rotate per triangle
   always_ff @(posedge clock) begin
      if (cmd.shift_in) begin
         p_ff[0] <= p_ff[1];
         p_ff[1] <= p_ff[2];
         p_ff[2][0] <= in_x; p_ff[2][1] <= in_y; p_ff[2][2] <= in_z;
      end else if (cmd.load_last) begin
         p_ff[3][0] <= in_x; p_ff[3][1] <= in_y; p_ff[3][2] <= in_z;
      end else if (cmd.op == OP_ROT) begin
         p_ff[0] <= p_ff[1];
         p_ff[1] <= p_ff[2];
         p_ff[2] <= p_ff[3];
         p_ff[3] <= p_ff[0];
      end
   end

   // Arithmetic micro-operations
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         area_ff   <= '0;
         num_ff[0] <= '0;
         num_ff[1] <= '0;
         num_ff[2] <= '0;
      end
      case (cmd.op)
         OP_CRX_LD: begin
            opa_ff <= MUL_W'(p_ff[1][0]) - MUL_W'(p_ff[0][0]);
            opb_ff <= MUL_W'(p_ff[2][1]) - MUL_W'(p_ff[0][1]);
         end
         OP_CRY_LD: begin
            opa_ff <= MUL_W'(p_ff[1][1]) - MUL_W'(p_ff[0][1]);
            opb_ff <= MUL_W'(p_ff[2][0]) - MUL_W'(p_ff[0][0]);
         end
         OP_MUL:    prod_ff <= opa_ff * opb_ff;
         OP_CR_SET: cr_ff <= signed'(prod_ff[CROSS_W-1:0]);
         OP_CR_SUB: cr_ff <= cr_ff - signed'(prod_ff[CROSS_W-1:0]);
         OP_ABS:    a2_ff <= cr_ff[CROSS_W-1] ? CROSS_W'(-cr_ff) : CROSS_W'(cr_ff);
         OP_AREA:   area_ff <= area_ff + AREA_W'(a2_ff);
         OP_NLO_LD: begin
            opa_ff <= signed'(MUL_W'(a2_ff[SUM_W-1:0]));
            opb_ff <= axis_sum;
         end
         OP_NHI_LD: begin
            opa_ff <= signed'(MUL_W'(a2_ff[CROSS_W-1:SUM_W]));
            opb_ff <= axis_sum;
         end
         OP_NLO_ACC: begin
            case (cmd.axis)
               AXIS_Y:  num_ff[1] <= num_ff[1] + NUM_W'(prod_ff);
               AXIS_Z:  num_ff[2] <= num_ff[2] + NUM_W'(prod_ff);
               default: num_ff[0] <= num_ff[0] + NUM_W'(prod_ff);
            endcase
         end
         OP_NHI_ACC: begin
            case (cmd.axis)
               AXIS_Y:  num_ff[1] <= num_ff[1] + (NUM_W'(prod_ff) <<< SUM_W);
               AXIS_Z:  num_ff[2] <= num_ff[2] + (NUM_W'(prod_ff) <<< SUM_W);
               default: num_ff[0] <= num_ff[0] + (NUM_W'(prod_ff) <<< SUM_W);
            endcase
         end
         OP_DEN:    den_ff <= DEN_W'(area_ff) + (DEN_W'(area_ff) << 1);
         OP_DIV_INIT: begin
            neg_ff <= num_sel[NUM_W-1];
            quo_ff <= num_mag;
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (fits) begin
               rem_ff <= DEN_W'(shifted - {1'b0, den_ff});
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[DEN_W-1:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
         end
         OP_DIV_DONE: begin
            case (cmd.axis)
               AXIS_Y:  res_ff[1] <= OUT_WIDTH'(signed'(res_cw));
               AXIS_Z:  res_ff[2] <= OUT_WIDTH'(signed'(res_cw));
               default: res_ff[0] <= OUT_WIDTH'(signed'(res_cw));
            endcase
         end
         OP_OUT: begin
            rsp_ff.status <= cmd.out_status;
            if (cmd.out_status == ST_OK) begin
               rsp_ff.centroid_x <= res_ff[0];
               rsp_ff.centroid_y <= res_ff[1];
               rsp_ff.centroid_z <= res_ff[2];
            end else begin
               rsp_ff.centroid_x <= '0;
               rsp_ff.centroid_y <= '0;
               rsp_ff.centroid_z <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign dp_status.den_zero = (den_ff == '0);
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/qcw_controller.sv =====
// Controller: vertex counting and the micro-operation sequence for one quad.
`timescale 1ns / 1ps
module qcw_controller
   import qcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_CRX_LD, S_CRX_MUL, S_CRX_WR, S_CRY_LD, S_CRY_MUL, S_CRY_WR,
      S_ABS, S_AREA, S_NLO_LD, S_NLO_MUL, S_NLO_ACC, S_NHI_LD, S_NHI_MUL,
      S_NHI_ACC, S_ROT, S_DEN, S_CHK, S_DIV_INIT, S_DIV_STEP, S_DIV_DONE, S_FIN
   } state_type;

   state_type              state_ff;
   logic [2:0]             count_ff;
   logic [1:0]             tri_ff;
   logic [1:0]             axis_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   status_type             status_ff;
   logic                   rsp_valid_ff;
   logic                   accept;
   logic                   out_load;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   // Decode the state into a datapath command
   always_comb begin
      cmd.axis       = axis_ff;
      cmd.out_status = status_ff;
      cmd.shift_in   = accept && !req_last && (count_ff < VERTS_HELD);
      cmd.load_last  = accept && req_last;
      cmd.clear      = accept && req_last;
      case (state_ff)
         S_CRX_LD:   cmd.op = OP_CRX_LD;
         S_CRY_LD:   cmd.op = OP_CRY_LD;
         S_CRX_MUL,
         S_CRY_MUL,
         S_NLO_MUL,
         S_NHI_MUL:  cmd.op = OP_MUL;
         S_CRX_WR:   cmd.op = OP_CR_SET;
         S_CRY_WR:   cmd.op = OP_CR_SUB;
         S_ABS:      cmd.op = OP_ABS;
         S_AREA:     cmd.op = OP_AREA;
         S_NLO_LD:   cmd.op = OP_NLO_LD;
         S_NHI_LD:   cmd.op = OP_NHI_LD;
         S_NLO_ACC:  cmd.op = OP_NLO_ACC;
         S_NHI_ACC:  cmd.op = OP_NHI_ACC;
         S_ROT:      cmd.op = OP_ROT;
         S_DEN:      cmd.op = OP_DEN;
         S_DIV_INIT: cmd.op = OP_DIV_INIT;
         S_DIV_STEP: cmd.op = OP_DIV_STEP;
         S_DIV_DONE: cmd.op = OP_DIV_DONE;
         S_FIN:      cmd.op = out_load ? OP_OUT : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // Hold state, counters and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tri_ff       <= '0;
         axis_ff      <= AXIS_X;
         div_cnt_ff   <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (!req_last) begin
                     if (count_ff < COUNT_MAX) count_ff <= count_ff + 3'd1;
                  end else begin
                     count_ff <= '0;
                     tri_ff   <= '0;
                     axis_ff  <= AXIS_X;
                     if (count_ff == VERTS_HELD) begin
                        state_ff <= S_CRX_LD;
                     end else begin
                        status_ff <= ST_COUNT;
                        state_ff  <= S_FIN;
                     end
                  end
               end
            end
            S_CRX_LD:  state_ff <= S_CRX_MUL;
            S_CRX_MUL: state_ff <= S_CRX_WR;
            S_CRX_WR:  state_ff <= S_CRY_LD;
            S_CRY_LD:  state_ff <= S_CRY_MUL;
            S_CRY_MUL: state_ff <= S_CRY_WR;
            S_CRY_WR:  state_ff <= S_ABS;
            S_ABS:     state_ff <= S_AREA;
            S_AREA: begin
               axis_ff  <= AXIS_X;
               state_ff <= S_NLO_LD;
            end
            S_NLO_LD:  state_ff <= S_NLO_MUL;
            S_NLO_MUL: state_ff <= S_NLO_ACC;
            S_NLO_ACC: state_ff <= S_NHI_LD;
            S_NHI_LD:  state_ff <= S_NHI_MUL;
            S_NHI_MUL: state_ff <= S_NHI_ACC;
            S_NHI_ACC: begin
               if (axis_ff == AXIS_Z) begin
                  state_ff <= S_ROT;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_NLO_LD;
               end
            end
            S_ROT: begin
               tri_ff <= tri_ff + 2'd1;
               state_ff <= (tri_ff == TRI_LAST) ? S_DEN : S_CRX_LD;
            end
            S_DEN:     state_ff <= S_CHK;
            S_CHK: begin
               axis_ff <= AXIS_X;
               if (dp_status.den_zero) begin
                  status_ff <= ST_AREA;
                  state_ff  <= S_FIN;
               end else begin
                  state_ff <= S_DIV_INIT;
               end
            end
            S_DIV_INIT: begin
               div_cnt_ff <= '0;
               state_ff   <= S_DIV_STEP;
            end
            S_DIV_STEP: begin
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) state_ff <= S_DIV_DONE;
            end
            S_DIV_DONE: begin
               if (axis_ff == AXIS_Z) begin
                  status_ff <= ST_OK;
                  state_ff  <= S_FIN;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_DIV_INIT;
               end
            end
            S_FIN: begin
               if (out_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/quad_centroid_weighted_unit.sv =====
// Top level of the area-weighted quadrilateral centroid unit.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_type  (one vertex per transaction)
//   rsp_      out        rsp_valid/rsp_stall   rsp_type  (one centroid per quad)
//
// A vertex without the last flag is counted and, up to the third, stored. A flagged
// fourth vertex runs each triangle on the one shared multiplier, then three
// restoring divisions at one quotient bit per cycle.
// A flagged vertex at a wrong count goes straight to the result with a count status.
// Reset is synchronous; it clears the vertex count and all control state.
// A stalled result holds in the output register; the next quad's vertices are
// still taken, and its result waits until the output register frees.
`timescale 1ns / 1ps
module quad_centroid_weighted_unit
   import qcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type       cmd;
   dp_status_type dp_status;

   qcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_vertex),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   qcw_datapath u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_data  (req_data),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/qcw_checker.sv =====
// Port-level assertions for the centroid unit, bound to the top level.
`timescale 1ns / 1ps
module qcw_checker
   import qcw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Drop the centroid on an error status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |->
         (rsp_data.centroid_x == 0) && (rsp_data.centroid_y == 0) &&
         (rsp_data.centroid_z == 0))
      else $error("error result carries a centroid");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A plain vertex never brings a result at once
   a_plain_vertex: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.last_vertex && !rsp_valid |=> !rsp_valid)
      else $error("result without a last vertex");

endmodule

bind quad_centroid_weighted_unit qcw_checker u_qcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
